// ===== sv/swhc_pkg.sv =====
`timescale 1ns / 1ps

package swhc_pkg;

    localparam int TS_W   = 31;
    localparam int CNT_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [TS_W-1:0]  t_ts;
    typedef logic [CNT_W-1:0] t_cnt;

    // broadcast from the control to every bucket cell
    typedef struct packed {
        logic hit_we;
        t_ts  ts;
    } t_cell_ctl;

endpackage

// ===== sv/sliding_window_hit_counter.sv =====
`timescale 1ns / 1ps
// hit: the reciprocal multiply is registered, then the remainder (bucket index), then the
//   bucket write; the write and the return to ready both fall on the same edge
// query: a sum token walks the row of WINDOW bucket cells, one cell per cycle; the result is
//   registered as the total, then in the output register; the input is ready again as it enters
//   the output register, later only while an earlier result still waits to be taken
// one item in work at a time; the output register lets the next item in while a result waits
// reset: synchronous, active low; clears every bucket time and count at once

module sliding_window_hit_counter #(
    parameter int WINDOW = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [30:0] timestamp, [31] zero
    input  logic        i_s_axis_tuser,  // [0] kind: 0 hit, 1 query
    // result item
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata   // [31:0] hit_total
);

    localparam int IW = $clog2(WINDOW);

    // item kinds
    localparam logic KIND_HIT   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // control states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_HMOD  = 2'd1;
    localparam logic [1:0] ST_QUERY = 2'd2;
    localparam logic [1:0] ST_QDONE = 2'd3;

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    swhc_pkg::t_ts  r_ts;
    logic           r_q_go;
    swhc_pkg::t_cnt r_total;
    logic           r_out_vld;
    swhc_pkg::t_cnt r_out_data;

    logic           in_acc;
    logic           mod_start;
    logic           mod_done;
    logic [IW-1:0]  mod_rem;
    logic           out_free;

    swhc_pkg::t_cell_ctl cell_ctl;
    logic [WINDOW-1:0]   cell_sel;
    logic [WINDOW:0]     chain_vld;
    swhc_pkg::t_cnt      chain_sum [WINDOW+1];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign mod_start       = in_acc && (i_s_axis_tuser == KIND_HIT);
    assign out_free        = !r_out_vld || i_m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_axis_tuser == KIND_QUERY) ? ST_QUERY : ST_HMOD;
                end
            end
            ST_HMOD: begin
                if (mod_done) n_state = ST_IDLE;
            end
            ST_QUERY: begin
                if (chain_vld[WINDOW]) n_state = ST_QDONE;
            end
            ST_QDONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_q_go    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_q_go  <= in_acc && (i_s_axis_tuser == KIND_QUERY);
            if (r_state == ST_QDONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // item timestamp, shared by the hit write and the query walk; also the query total and output data
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ts <= i_s_axis_tdata[swhc_pkg::TS_W-1:0];
        end
        if (chain_vld[WINDOW]) begin
            r_total <= chain_sum[WINDOW];
        end
        if (r_state == ST_QDONE && out_free) begin
            r_out_data <= r_total;
        end
    end

    // bucket index = timestamp mod WINDOW
    swhc_mod #(
        .WINDOW (WINDOW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (i_s_axis_tdata[swhc_pkg::TS_W-1:0]),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    assign cell_ctl.hit_we = mod_done;
    assign cell_ctl.ts     = r_ts;

    // the query enters the first cell with an empty sum
    assign chain_vld[0] = r_q_go;
    assign chain_sum[0] = '0;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        assign cell_sel[g] = (mod_rem == IW'(g));

        swhc_cell #(
            .WINDOW (WINDOW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_sel   (cell_sel[g]),
            .i_vld   (chain_vld[g]),
            .i_sum   (chain_sum[g]),
            .o_vld   (chain_vld[g+1]),
            .o_sum   (chain_sum[g+1])
        );
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // only one sum token may ever be in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(chain_vld) <= 1)
        else $error("more than one query token in the cell row");

    // the row finishes only while a query is in work
    a_tail_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_vld[WINDOW] |-> r_state == ST_QUERY)
        else $error("query sum left the row outside of a query");

    // a bucket write only ends a hit
    a_write_in_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> r_state == ST_HMOD)
        else $error("bucket write outside of a hit");

    // a hit never overlaps a query walk
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> !(|chain_vld))
        else $error("bucket write during a query walk");

endmodule

// ===== sv/swhc_mod.sv =====
`timescale 1ns / 1ps

module swhc_mod #(
    parameter int WINDOW = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  swhc_pkg::t_ts             i_value,
    output logic                      o_done,
    output logic [$clog2(WINDOW)-1:0] o_rem
);

    localparam int IW = $clog2(WINDOW);
    localparam int SH = swhc_pkg::TS_W + IW;
    localparam int PW = 2 * swhc_pkg::TS_W + 1;

    // reciprocal rounded up: the quotient is exact for every timestamp
    localparam logic [63:0] RECIP_L =
        ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [swhc_pkg::TS_W:0] RECIP = RECIP_L[swhc_pkg::TS_W:0];
    localparam logic [IW-1:0]           W_LO  = IW'(WINDOW);

    logic          r_stage;
    logic          r_done;
    logic [IW-1:0] r_val;
    logic [IW-1:0] r_q;
    logic [IW-1:0] r_rem;

    logic [PW-1:0] prod;
    logic [IW-1:0] n_rem;

    // quotient by reciprocal multiply, remainder from its low bits
    always_comb begin
        prod  = PW'(i_value) * PW'(RECIP);
        n_rem = r_val - (r_q * W_LO);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value[IW-1:0];
            r_q   <= prod[SH+IW-1:SH];
        end
        if (r_stage) begin
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== sv/swhc_cell.sv =====
`timescale 1ns / 1ps

module swhc_cell #(
    parameter int WINDOW = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  swhc_pkg::t_cell_ctl i_ctl,
    input  logic                i_sel,
    input  logic                i_vld,
    input  swhc_pkg::t_cnt      i_sum,
    output logic                o_vld,
    output swhc_pkg::t_cnt      o_sum
);

    localparam logic signed [swhc_pkg::TS_W:0] WIN_S = (swhc_pkg::TS_W+1)'(WINDOW);

    swhc_pkg::t_ts  r_time;
    swhc_pkg::t_cnt r_count;
    logic           r_vld;
    swhc_pkg::t_cnt r_sum;

    logic signed [swhc_pkg::TS_W:0] diff;
    logic                           in_win;
    logic [swhc_pkg::CNT_W:0]       wide_sum;
    swhc_pkg::t_cnt                 n_sum;

    always_comb begin
        diff     = $signed({1'b0, i_ctl.ts} - {1'b0, r_time});
        in_win   = diff < WIN_S;
        wide_sum = {1'b0, i_sum} + {1'b0, (in_win ? r_count : '0)};
        n_sum    = wide_sum[swhc_pkg::CNT_W] ? swhc_pkg::CNT_MAX
                                             : wide_sum[swhc_pkg::CNT_W-1:0];
    end

    // bucket store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_count <= '0;
        end else if (i_ctl.hit_we && i_sel) begin
            if (r_time != i_ctl.ts) begin
                r_time  <= i_ctl.ts;
                r_count <= swhc_pkg::CNT_W'(1);
            end else if (r_count != swhc_pkg::CNT_MAX) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // running sum handed to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_sum <= n_sum;
        end
    end

    assign o_vld = r_vld;
    assign o_sum = r_sum;

endmodule
